>>> rtl/dns_message_parser_top_macros.svh
// dns message parser assertion macros
// used by rtl modules that carry clk_i and rst_ni
`ifndef DNS_MESSAGE_PARSER_TOP_MACROS_SVH
`define DNS_MESSAGE_PARSER_TOP_MACROS_SVH

// property checked at every rising clock edge outside reset
`define DMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold
`define DMP_ASSERT_NEVER(lbl, cond, msg) \
  `DMP_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/dmp_pkg.sv
// dns message parser package: stage codes, result kinds, error codes, result type
// no dependencies
`default_nettype none

package dmp_pkg;

  localparam int unsigned MAX_QUERIES_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned OFFSET_BITS       = 14;
  localparam logic [7:0]  DOT_CHAR          = 8'h2E;

  typedef enum logic [6:0] {
    ST_HEADER     = 7'b0000001,
    ST_NAME_LEN   = 7'b0000010,
    ST_NAME_CHARS = 7'b0000100,
    ST_QTAIL      = 7'b0001000,
    ST_AHDR       = 7'b0010000,
    ST_ADATA      = 7'b0100000,
    ST_IDLE       = 7'b1000000
  } stage_e;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_NAME_CHAR = 3'd1;
  localparam logic [2:0] KIND_QUERY_END = 3'd2;
  localparam logic [2:0] KIND_ANS_HDR   = 3'd3;
  localparam logic [2:0] KIND_ANS_DATA  = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;
  localparam logic [2:0] KIND_ERROR     = 3'd6;

  localparam logic [2:0] ERR_SHORT_HEADER  = 3'd0;
  localparam logic [2:0] ERR_SHORT_NAME    = 3'd1;
  localparam logic [2:0] ERR_SHORT_QUERY   = 3'd2;
  localparam logic [2:0] ERR_SHORT_ANS_HDR = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN_OFS   = 3'd4;
  localparam logic [2:0] ERR_SHORT_DATA    = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY_QRY  = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_or_data;
    logic [3:0]  qry_idx;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] msg_id;
    logic [15:0] header_flags;
    logic [15:0] query_count;
    logic [15:0] answer_count;
    logic [15:0] data_length;
    logic [2:0]  error_code;
  } res_t;

  function automatic res_t res_kind(input logic [2:0] kind);
    res_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic res_t res_err(input logic [2:0] code);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dmp_in_if.sv
// input channel: one message byte per transaction
// no dependencies
`default_nettype none

interface dmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/dmp_out_if.sv
// output channel: one parse result per transaction
// no dependencies
`default_nettype none

interface dmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  char_or_data;
  logic [3:0]  qry_idx;
  logic [15:0] record_type;
  logic [15:0] record_class;
  logic [31:0] time_to_live;
  logic [15:0] msg_id;
  logic [15:0] header_flags;
  logic [15:0] query_count;
  logic [15:0] answer_count;
  logic [15:0] data_length;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output char_or_data, output qry_idx,
                  output record_type, output record_class, output time_to_live,
                  output msg_id, output header_flags, output query_count,
                  output answer_count, output data_length, output error_code,
                  input ready);
  modport sink (input valid, input kind, input char_or_data, input qry_idx,
                input record_type, input record_class, input time_to_live,
                input msg_id, input header_flags, input query_count,
                input answer_count, input data_length, input error_code,
                output ready);
endinterface

`default_nettype wire

>>> rtl/dns_message_parser_top.sv
// dns message parser top level: byte parser, offset store, result queue
// depends on dmp_pkg, dmp_in_if, dmp_out_if, dmp_offset_store, dmp_result_queue
//
//  channel  dir  payload                         transaction
//  in_i     in   data_byte, last_byte            valid & ready
//  out_o    out  kind .. error_code (12 fields)  valid & ready
//
//  one byte per cycle while the result queue has room; each byte yields zero, one or two results
//  results go into a four entry queue; input is held off while fewer than two slots are free
//  offset match runs against the stored offsets in parallel, registered once per cycle
//  reset clears all control state; the offset store needs no clearing
`default_nettype none

module dns_message_parser_top
  import dmp_pkg::*;
#(
  parameter int unsigned MaxQueries   = MAX_QUERIES_DEF,
  parameter int unsigned PositionBits = POSITION_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dmp_in_if.sink    in_i,
  dmp_out_if.source out_o
);

  `include "dns_message_parser_top_macros.svh"

  localparam int unsigned IdxW = (MaxQueries > 1) ? $clog2(MaxQueries) : 1;

  stage_e                  st_q, st_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [15:0]             qa_q, qa_d, aa_q, aa_d, rc_q, rc_d, bl_q, bl_d, po_q, po_d;
  logic [63:0]             g_q, g_d;
  logic                    ns_q, ns_d;
  logic [3:0]              fs_q, fs_d;

  logic        in_fire, room, last, nm;
  logic [7:0]  b;
  logic        p_v, t_v;
  res_t        p, t;
  logic        wr_en;
  logic        found;
  logic [IdxW-1:0] hit;

  assign in_fire    = in_i.valid & in_i.ready;
  assign in_i.ready = room;
  assign b          = in_i.data_byte;
  assign last       = in_i.last_byte;

  always_comb begin
    st_d  = st_q;
    pos_d = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
    qa_d  = qa_q;
    aa_d  = aa_q;
    rc_d  = rc_q;
    bl_d  = bl_q;
    po_d  = po_q;
    g_d   = g_q;
    ns_d  = ns_q;
    fs_d  = fs_q;
    p_v   = 1'b0;
    p     = '0;
    t_v   = 1'b0;
    t     = '0;
    wr_en = 1'b0;
    nm    = 1'b0;

    case (st_q)
      ST_HEADER: begin
        if (pos_q < PositionBits'(4)) begin
          g_d = {32'd0, g_q[23:0], b};
        end else if (pos_q < PositionBits'(6)) begin
          qa_d = {qa_q[7:0], b};
        end else if (pos_q < PositionBits'(8)) begin
          aa_d = {aa_q[7:0], b};
        end
        if (pos_q >= PositionBits'(11)) begin
          p_v            = 1'b1;
          p              = res_kind(KIND_HEADER);
          p.msg_id       = g_q[31:16];
          p.header_flags = g_q[15:0];
          p.query_count  = qa_q;
          p.answer_count = aa_q;
          rc_d           = '0;
          if (qa_q > 16'(MaxQueries)) begin
            t_v = 1'b1;
            t   = res_err(ERR_TOO_MANY_QRY);
          end else if (qa_q != '0) begin
            st_d = ST_NAME_LEN;
            ns_d = 1'b0;
            if (last) begin
              t_v = 1'b1;
              t   = res_err(ERR_SHORT_NAME);
            end
          end else if (aa_q == '0) begin
            t_v = 1'b1;
            t   = res_kind(KIND_DONE);
          end else begin
            st_d = ST_AHDR;
            fs_d = '0;
            if (last) begin
              t_v = 1'b1;
              t   = res_err(ERR_SHORT_ANS_HDR);
            end
          end
        end else if (last) begin
          t_v = 1'b1;
          t   = res_err(ERR_SHORT_HEADER);
        end
      end
      ST_NAME_LEN: begin
        wr_en = !ns_q && (rc_q < 16'(MaxQueries));
        if (b == 8'd0) begin
          ns_d = 1'b0;
          st_d = ST_QTAIL;
          fs_d = '0;
          if (last) begin
            t_v = 1'b1;
            t   = res_err(ERR_SHORT_QUERY);
          end
        end else begin
          if (ns_q) begin
            p_v            = 1'b1;
            p              = res_kind(KIND_NAME_CHAR);
            p.char_or_data = DOT_CHAR;
          end
          ns_d = 1'b1;
          bl_d = {8'd0, b};
          st_d = ST_NAME_CHARS;
          if (last) begin
            t_v = 1'b1;
            t   = res_err(ERR_SHORT_NAME);
          end
        end
      end
      ST_NAME_CHARS: begin
        p_v            = 1'b1;
        p              = res_kind(KIND_NAME_CHAR);
        p.char_or_data = b;
        bl_d           = (bl_q != '0) ? bl_q - 16'd1 : bl_q;
        if (bl_d == '0) begin
          st_d = ST_NAME_LEN;
          if (last) begin
            t_v = 1'b1;
            t   = res_err(ERR_SHORT_QUERY);
          end
        end else if (last) begin
          t_v = 1'b1;
          t   = res_err(ERR_SHORT_NAME);
        end
      end
      ST_QTAIL: begin
        g_d  = {32'd0, g_q[23:0], b};
        fs_d = fs_q + 4'd1;
        if (fs_d >= 4'd4) begin
          p_v            = 1'b1;
          p              = res_kind(KIND_QUERY_END);
          p.qry_idx      = rc_q[3:0];
          p.record_type  = g_d[31:16];
          p.record_class = g_d[15:0];
          rc_d           = rc_q + 16'd1;
          if (rc_d >= qa_q) begin
            rc_d = '0;
            if (aa_q == '0) begin
              t_v = 1'b1;
              t   = res_kind(KIND_DONE);
            end else begin
              st_d = ST_AHDR;
              fs_d = '0;
              if (last) begin
                t_v = 1'b1;
                t   = res_err(ERR_SHORT_ANS_HDR);
              end
            end
          end else begin
            st_d = ST_NAME_LEN;
            ns_d = 1'b0;
            if (last) begin
              t_v = 1'b1;
              t   = res_err(ERR_SHORT_NAME);
            end
          end
        end else if (last) begin
          t_v = 1'b1;
          t   = res_err(ERR_SHORT_QUERY);
        end
      end
      ST_AHDR: begin
        if (fs_q < 4'd2) begin
          po_d = {po_q[7:0], b};
        end else if (fs_q < 4'd10) begin
          g_d = {g_q[55:0], b};
        end else begin
          bl_d = {bl_q[7:0], b};
        end
        fs_d = fs_q + 4'd1;
        if (fs_d >= 4'd12) begin
          if (!found) begin
            t_v = 1'b1;
            t   = res_err(ERR_UNKNOWN_OFS);
          end else begin
            p_v            = 1'b1;
            p              = res_kind(KIND_ANS_HDR);
            p.qry_idx      = 4'(hit);
            p.record_type  = g_d[63:48];
            p.record_class = g_d[47:32];
            p.time_to_live = g_d[31:0];
            p.data_length  = bl_d;
            if (bl_d == '0) begin
              rc_d = rc_q + 16'd1;
              if (rc_d >= aa_q) begin
                t_v = 1'b1;
                t   = res_kind(KIND_DONE);
              end else begin
                fs_d = '0;
                if (last) begin
                  t_v = 1'b1;
                  t   = res_err(ERR_SHORT_ANS_HDR);
                end
              end
            end else begin
              st_d = ST_ADATA;
              if (last) begin
                t_v = 1'b1;
                t   = res_err(ERR_SHORT_DATA);
              end
            end
          end
        end else if (last) begin
          t_v = 1'b1;
          t   = res_err(ERR_SHORT_ANS_HDR);
        end
      end
      ST_ADATA: begin
        p_v            = 1'b1;
        p              = res_kind(KIND_ANS_DATA);
        p.char_or_data = b;
        bl_d           = (bl_q != '0) ? bl_q - 16'd1 : bl_q;
        if (bl_d == '0) begin
          rc_d = rc_q + 16'd1;
          if (rc_d >= aa_q) begin
            t_v = 1'b1;
            t   = res_kind(KIND_DONE);
          end else begin
            st_d = ST_AHDR;
            fs_d = '0;
            if (last) begin
              t_v = 1'b1;
              t   = res_err(ERR_SHORT_ANS_HDR);
            end
          end
        end else if (last) begin
          t_v = 1'b1;
          t   = res_err(ERR_SHORT_DATA);
        end
      end
      default: begin
        nm = last;
      end
    endcase

    // done or error closes the message
    if (t_v) begin
      if (last) begin
        nm = 1'b1;
      end else begin
        st_d = ST_IDLE;
      end
    end

    if (nm) begin
      st_d  = ST_HEADER;
      pos_d = '0;
      qa_d  = '0;
      aa_d  = '0;
      rc_d  = '0;
      bl_d  = '0;
      g_d   = '0;
      ns_d  = 1'b0;
      fs_d  = '0;
      po_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_HEADER;
      pos_q <= '0;
      qa_q  <= '0;
      aa_q  <= '0;
      rc_q  <= '0;
      bl_q  <= '0;
      g_q   <= '0;
      ns_q  <= 1'b0;
      fs_q  <= '0;
      po_q  <= '0;
    end else if (in_fire) begin
      st_q  <= st_d;
      pos_q <= pos_d;
      qa_q  <= qa_d;
      aa_q  <= aa_d;
      rc_q  <= rc_d;
      bl_q  <= bl_d;
      g_q   <= g_d;
      ns_q  <= ns_d;
      fs_q  <= fs_d;
      po_q  <= po_d;
    end
  end

  dmp_offset_store #(
    .MaxQueries (MaxQueries),
    .IdxW       (IdxW)
  ) u_ofs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_fire & wr_en),
    .wr_idx_i (rc_q[IdxW-1:0]),
    .wr_ofs_i (OFFSET_BITS'(pos_q)),
    .key_i    (po_q[OFFSET_BITS-1:0]),
    .limit_i  (qa_q),
    .found_o  (found),
    .hit_o    (hit)
  );

  dmp_result_queue u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (in_fire & (p_v | t_v)),
    .push1_i (in_fire & p_v & t_v),
    .res0_i  (p_v ? p : t),
    .res1_i  (t),
    .room_o  (room),
    .out_o   (out_o)
  );

  `DMP_ASSERT(a_idle_holds, in_fire && st_q == ST_IDLE && !last |=> st_q == ST_IDLE,
              "left idle before message end")
  `DMP_ASSERT(a_close_stage, in_fire && t_v |=> (st_q == ST_IDLE || st_q == ST_HEADER),
              "message not closed after done or error")
  `DMP_ASSERT(a_pos_grows, in_fire && !nm |=> pos_q >= $past(pos_q),
              "byte position went back inside a message")

endmodule

`default_nettype wire

>>> rtl/dmp_offset_store.sv
// query name offset store with parallel match against an answer offset
// depends on dmp_pkg
`default_nettype none

module dmp_offset_store
  import dmp_pkg::*;
#(
  parameter int unsigned MaxQueries = MAX_QUERIES_DEF,
  parameter int unsigned IdxW = (MaxQueries > 1) ? $clog2(MaxQueries) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [IdxW-1:0]        wr_idx_i,
  input  wire logic [OFFSET_BITS-1:0] wr_ofs_i,
  input  wire logic [OFFSET_BITS-1:0] key_i,
  input  wire logic [15:0]            limit_i,
  output logic                        found_o,
  output logic [IdxW-1:0]             hit_o
);

  logic [OFFSET_BITS-1:0] mem [MaxQueries];
  logic                   found_d, found_q;
  logic [IdxW-1:0]        hit_d, hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_ofs_i;
    end
  end

  // lowest matching index wins
  always_comb begin
    found_d = 1'b0;
    hit_d   = '0;
    for (int i = MaxQueries - 1; i >= 0; i--) begin
      if (mem[i] == key_i && 17'(i) < {1'b0, limit_i}) begin
        found_d = 1'b1;
        hit_d   = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= '0;
    end else begin
      found_q <= found_d;
      hit_q   <= hit_d;
    end
  end

  assign found_o = found_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

>>> rtl/dmp_result_queue.sv
// four entry result queue taking up to two results per cycle
// depends on dmp_pkg and dmp_out_if
`default_nettype none

module dmp_result_queue
  import dmp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push0_i,
  input  wire logic  push1_i,
  input  wire res_t  res0_i,
  input  wire res_t  res1_i,
  output logic       room_o,
  dmp_out_if.source  out_o
);

  `include "dns_message_parser_top_macros.svh"

  res_t       mem [4];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  res_t       head;

  assign pop  = out_o.valid & out_o.ready;
  assign head = mem[rptr_q];

  always_comb begin
    wptr_d = wptr_q + 2'(push0_i) + 2'(push1_i);
    rptr_d = rptr_q + 2'(pop);
    cnt_d  = cnt_q + 3'(push0_i) + 3'(push1_i) - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem[wptr_q] <= res0_i;
    end
    if (push1_i) begin
      mem[wptr_q + 2'd1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign room_o             = (cnt_q <= 3'd2);
  assign out_o.valid        = (cnt_q != 3'd0);
  assign out_o.kind         = head.kind;
  assign out_o.char_or_data = head.char_or_data;
  assign out_o.qry_idx      = head.qry_idx;
  assign out_o.record_type  = head.record_type;
  assign out_o.record_class = head.record_class;
  assign out_o.time_to_live = head.time_to_live;
  assign out_o.msg_id       = head.msg_id;
  assign out_o.header_flags = head.header_flags;
  assign out_o.query_count  = head.query_count;
  assign out_o.answer_count = head.answer_count;
  assign out_o.data_length  = head.data_length;
  assign out_o.error_code   = head.error_code;

  `DMP_ASSERT_NEVER(a_q_overflow, cnt_q > 3'd4, "result queue overflow")
  `DMP_ASSERT(a_q_push_order, push1_i |-> push0_i, "second result pushed alone")
  `DMP_ASSERT(a_q_ptr_gap, ({1'b0, wptr_q - rptr_q} == cnt_q) || (cnt_q == 3'd4 && wptr_q == rptr_q),
              "queue pointers disagree with count")

endmodule

`default_nettype wire

>>> dv/tb_dns_message_parser_top.sv
// testbench for dns_message_parser_top: drives dns messages byte by byte and
// checks every parse result against an in-bench parser model
// depends on dmp_pkg, dmp_in_if, dmp_out_if and the rtl of dns_message_parser_top
`timescale 1ns / 1ps

module tb_dns_message_parser_top;
  import dmp_pkg::*;

  localparam int unsigned MaxQry = MAX_QUERIES_DEF;
  localparam int unsigned PosMax = (1 << POSITION_BITS_DEF) - 1;
  localparam longint unsigned CycleLimit = 400000;

  typedef enum int {
    P_HEADER, P_NAME_LEN, P_NAME_CHARS, P_QTAIL, P_AHDR, P_ADATA, P_IDLE
  } parse_e;

  logic clk_i;
  logic rst_ni;

  dmp_in_if  in_ch ();
  dmp_out_if out_ch ();

  dns_message_parser_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser model state
  parse_e      p_stage;
  int unsigned p_pos, p_nq, p_na, p_rec, p_left, p_step, p_pend;
  logic [63:0] p_gather;
  bit          p_started;
  logic [13:0] p_offsets [MaxQry];

  res_t        expected_results[$];
  int          error_count;
  int          result_count;
  int          byte_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  longint unsigned cycle_count;

  // message under construction
  logic [7:0]  msg[$];

  task automatic restart_message();
    p_stage = P_HEADER;
    p_pos = 0; p_nq = 0; p_na = 0; p_rec = 0; p_left = 0;
    p_gather = '0; p_started = 0; p_step = 0; p_pend = 0;
  endtask

  function automatic res_t blank(logic [2:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic add_expected(res_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic add_byte(logic [7:0] v);
    msg.insert(msg.size(), v);
  endtask

  task automatic finish_msg(logic [2:0] k, logic [2:0] code, bit last);
    res_t r;
    r = blank(k);
    if (k == KIND_ERROR) r.error_code = code;
    add_expected(r);
    if (last) restart_message();
    else p_stage = P_IDLE;
  endtask

  task automatic open_answers(bit last);
    p_rec = 0;
    if (p_na == 0) begin
      finish_msg(KIND_DONE, 3'd0, last);
      return;
    end
    p_stage = P_AHDR;
    p_step = 0;
    if (last) finish_msg(KIND_ERROR, ERR_SHORT_ANS_HDR, last);
  endtask

  task automatic close_answer(bit last);
    p_rec = (p_rec + 1) & 16'hFFFF;
    if (p_rec >= p_na) begin
      finish_msg(KIND_DONE, 3'd0, last);
      return;
    end
    p_stage = P_AHDR;
    p_step = 0;
    if (last) finish_msg(KIND_ERROR, ERR_SHORT_ANS_HDR, last);
  endtask

  task automatic parse_byte(logic [7:0] b, bit last);
    int unsigned pos;
    res_t r;
    int unsigned hit;
    bit found;
    pos = p_pos;
    if (p_pos < PosMax) p_pos++;
    case (p_stage)
      P_HEADER: begin
        if (pos < 4) p_gather = ((p_gather << 8) | b) & 64'hFFFF_FFFF;
        else if (pos < 6) p_nq = ((p_nq << 8) | b) & 16'hFFFF;
        else if (pos < 8) p_na = ((p_na << 8) | b) & 16'hFFFF;
        if (pos >= 11) begin
          r = blank(KIND_HEADER);
          r.msg_id = p_gather[31:16];
          r.header_flags = p_gather[15:0];
          r.query_count = 16'(p_nq);
          r.answer_count = 16'(p_na);
          add_expected(r);
          if (p_nq > MaxQry) finish_msg(KIND_ERROR, ERR_TOO_MANY_QRY, last);
          else if (p_nq > 0) begin
            p_stage = P_NAME_LEN;
            p_rec = 0;
            p_started = 0;
            if (last) finish_msg(KIND_ERROR, ERR_SHORT_NAME, last);
          end else open_answers(last);
        end else if (last) finish_msg(KIND_ERROR, ERR_SHORT_HEADER, last);
      end
      P_NAME_LEN: begin
        if (!p_started && p_rec < MaxQry) p_offsets[p_rec] = pos[13:0];
        if (b == 0) begin
          p_started = 0;
          p_stage = P_QTAIL;
          p_step = 0;
          if (last) finish_msg(KIND_ERROR, ERR_SHORT_QUERY, last);
        end else begin
          if (p_started) begin
            r = blank(KIND_NAME_CHAR);
            r.char_or_data = DOT_CHAR;
            add_expected(r);
          end
          p_started = 1;
          p_left = {24'd0, b};
          p_stage = P_NAME_CHARS;
          if (last) finish_msg(KIND_ERROR, ERR_SHORT_NAME, last);
        end
      end
      P_NAME_CHARS: begin
        r = blank(KIND_NAME_CHAR);
        r.char_or_data = b;
        add_expected(r);
        if (p_left > 0) p_left--;
        if (p_left == 0) begin
          p_stage = P_NAME_LEN;
          if (last) finish_msg(KIND_ERROR, ERR_SHORT_QUERY, last);
        end else if (last) finish_msg(KIND_ERROR, ERR_SHORT_NAME, last);
      end
      P_QTAIL: begin
        p_gather = ((p_gather << 8) | b) & 64'hFFFF_FFFF;
        p_step++;
        if (p_step >= 4) begin
          r = blank(KIND_QUERY_END);
          r.qry_idx = p_rec[3:0];
          r.record_type = p_gather[31:16];
          r.record_class = p_gather[15:0];
          add_expected(r);
          p_rec = (p_rec + 1) & 16'hFFFF;
          if (p_rec >= p_nq) open_answers(last);
          else begin
            p_stage = P_NAME_LEN;
            p_started = 0;
            if (last) finish_msg(KIND_ERROR, ERR_SHORT_NAME, last);
          end
        end else if (last) finish_msg(KIND_ERROR, ERR_SHORT_QUERY, last);
      end
      P_AHDR: begin
        if (p_step < 2) p_pend = ((p_pend << 8) | b) & 16'hFFFF;
        else if (p_step < 10) p_gather = (p_gather << 8) | b;
        else p_left = ((p_left << 8) | b) & 16'hFFFF;
        p_step++;
        if (p_step >= 12) begin
          found = 0;
          hit = 0;
          for (int unsigned i = 0; i < p_nq && i < MaxQry; i++)
            if (!found && p_offsets[i] == p_pend[13:0]) begin
              found = 1;
              hit = i;
            end
          if (!found) finish_msg(KIND_ERROR, ERR_UNKNOWN_OFS, last);
          else begin
            r = blank(KIND_ANS_HDR);
            r.qry_idx = hit[3:0];
            r.record_type = p_gather[63:48];
            r.record_class = p_gather[47:32];
            r.time_to_live = p_gather[31:0];
            r.data_length = 16'(p_left);
            add_expected(r);
            if (p_left == 0) close_answer(last);
            else begin
              p_stage = P_ADATA;
              if (last) finish_msg(KIND_ERROR, ERR_SHORT_DATA, last);
            end
          end
        end else if (last) finish_msg(KIND_ERROR, ERR_SHORT_ANS_HDR, last);
      end
      P_ADATA: begin
        r = blank(KIND_ANS_DATA);
        r.char_or_data = b;
        add_expected(r);
        if (p_left > 0) p_left--;
        if (p_left == 0) close_answer(last);
        else if (last) finish_msg(KIND_ERROR, ERR_SHORT_DATA, last);
      end
      default: if (last) restart_message();
    endcase
  endtask

  // one transaction on the input channel; valid stays high for a following byte
  task automatic send_byte(logic [7:0] b, bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    parse_byte(b, last);
    byte_count++;
    @(negedge clk_i);
  endtask

  task automatic send_msg(int cut);
    int n;
    n = (cut >= 0 && cut < msg.size()) ? cut + 1 : msg.size();
    for (int i = 0; i < n; i++) send_byte(msg[i], i == n - 1);
  endtask

  task automatic put16(int unsigned v);
    add_byte(v[15:8]);
    add_byte(v[7:0]);
  endtask

  // well-formed message with random content; offsets point at real names unless bad_ofs is set
  task automatic build_msg(int nq, int na, bit bad_ofs, bit wild_len);
    int unsigned ofs[$];
    int labels, len, dl;
    msg.delete();
    put16($urandom);
    put16($urandom);
    put16(nq);
    put16(na);
    put16($urandom);
    put16($urandom);
    for (int q = 0; q < nq; q++) begin
      ofs.insert(ofs.size(), msg.size());
      if (wild_len) labels = 1;
      else labels = (nq > 4) ? $urandom_range(1) : $urandom_range(3);
      for (int l = 0; l < labels; l++) begin
        len = wild_len ? $urandom_range(128, 64) : $urandom_range(5, 1);
        add_byte(8'(len));
        for (int c = 0; c < len; c++) add_byte(8'($urandom));
      end
      add_byte(8'h00);
      put16($urandom);
      put16($urandom);
    end
    for (int a = 0; a < na; a++) begin
      if (bad_ofs || ofs.size() == 0) put16($urandom);
      else put16(ofs[$urandom_range(ofs.size() - 1)] | ($urandom_range(3) << 14));
      put16($urandom);
      put16($urandom);
      put16($urandom);
      put16($urandom);
      dl = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
      put16(dl);
      for (int d = 0; d < dl; d++) add_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.char_or_data, out_ch.qry_idx, out_ch.record_type,
              out_ch.record_class, out_ch.time_to_live, out_ch.msg_id,
              out_ch.header_flags, out_ch.query_count, out_ch.answer_count,
              out_ch.data_length, out_ch.error_code};
      result_count++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t result mismatch: expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  always @(negedge clk_i)
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("dns_message_parser_top regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    build_msg(0, 0, 0, 0); send_msg(-1);
    build_msg(1, 1, 0, 0); send_msg(-1);
    build_msg(1, 1, 0, 1); send_msg(-1);
    build_msg(1, 1, 1, 0); send_msg(-1);
    build_msg(MaxQry, 1, 0, 0); send_msg(-1);
    build_msg(0, 0, 0, 0);
    msg[4] = 8'h00; msg[5] = 8'(MaxQry + 1);
    send_msg(-1);
    build_msg(0, 0, 0, 0);
    msg[4] = 8'hFF; msg[5] = 8'hFF; msg[6] = 8'hFF; msg[7] = 8'hFF;
    send_msg(-1);
    for (int c = 0; c < 9; c += 3) begin
      build_msg(1, 1, 0, 0);
      send_msg($urandom_range(msg.size() - 1));
    end
    build_msg(0, 0, 0, 0); send_msg(5);
    msg.delete(); add_byte(8'hFF); send_msg(-1);
  endtask

  task automatic test_random(int n_bytes);
    int start;
    start = byte_count;
    while (byte_count - start < n_bytes) begin
      case ($urandom_range(9))
        0: begin
          msg.delete();
          repeat ($urandom_range(30, 1)) add_byte(8'($urandom));
          send_msg(-1);
        end
        1: begin
          build_msg($urandom_range(3), $urandom_range(3), 0, 0);
          send_msg($urandom_range(msg.size() - 1));
        end
        2: begin
          build_msg($urandom_range(2), $urandom_range(2, 1), 1, 0);
          send_msg(-1);
        end
        default: begin
          build_msg($urandom_range(3), $urandom_range(3), 0, 0);
          send_msg(-1);
        end
      endcase
    end
  endtask

  initial begin
    error_count = 0; result_count = 0; byte_count = 0; cycle_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    restart_message();
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(25);
    wait_drained();
    send_idle_pct = 59; recv_stall_pct = 0;  test_random(25);
    send_idle_pct = 0;  recv_stall_pct = 59; test_random(25);
    send_idle_pct = 13; recv_stall_pct = 13; test_random(25);
    send_idle_pct = 0;  recv_stall_pct = 0;
    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("sent %0d bytes of well-formed, truncated, bad-offset and random messages",
             byte_count);
    $display("checked %0d results, %0d mismatches", result_count, error_count);
    if (error_count == 0 && expected_results.size() == 0)
      $display("dns_message_parser_top regression: pass");
    else
      $display("dns_message_parser_top regression: fail");
    $finish;
  end

endmodule
